// ===== hw/rtl/point_in_polygon_ray_cast_assert.svh =====
// Assertion macros for the ray-cast point-in-polygon block.
// Both macros sample on clock and are disabled while reset is high.
`ifndef POINT_IN_POLYGON_RAY_CAST_ASSERT_SVH
`define POINT_IN_POLYGON_RAY_CAST_ASSERT_SVH

// same-cycle implication
`define PIPR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/pipr_pkg.sv =====
// Shared types and constants of the ray-cast point-in-polygon block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pipr_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int MIN_VERTICES       = 3;
   localparam int CSR_INDEX_BITS     = 8;

   // configuration register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POINT_X = 8'd0,
      CSR_POINT_Y = 8'd1
   } csr_reg_type;

   // orientation of a point triple
   typedef enum logic [1:0] {
      ORIENT_COLL = 2'd0,
      ORIENT_CW   = 2'd1,
      ORIENT_CCW  = 2'd2
   } orient_type;

   // per-edge flags that need no multiplier
   typedef struct packed {
      logic en;         // edge is tested
      logic box;        // point lies in the edge's bounding box
      logic side_diff;  // edge ends lie on different sides of the ray line
      logic ray_touch;  // an edge end lies on the ray
   } edge_flags_type;

endpackage

`default_nettype wire

// ===== hw/rtl/point_in_polygon_ray_cast.sv =====
// Ray-cast point-in-polygon test, fed one polygon vertex per transfer.
// Depends on pipr_pkg and point_in_polygon_ray_cast_assert.svh.
//
// Usage:
//   csr_*  : register writes (index 0 point_x, index 1 point_y), csr_ready is
//            always high; other indexes are dropped. Write only while idle.
//   req_*  : one vertex per transfer, req_last_vertex closes the polygon.
//   rsp_*  : one result per polygon, after the transfer of its last vertex.
//   A transfer happens at a clock edge with valid high and stall low.
// Throughput: one vertex per cycle while req_stall is low. Each vertex runs
//   its regular edge and, when last, the closing edge through two parallel
//   edge units of three multipliers each.
// Path: a last vertex passes the input register, then the product register,
//   and its result is shown from the result register.
// Stall: a stalled result holds in the output register; vertices that give
//   no result keep flowing behind it, and req_stall rises only when the
//   product stage holds a last vertex that cannot reach the output.
// Reset: clears point registers, pipeline valids, vertex count and parity;
//   the next vertex starts a new polygon.
`timescale 1ns / 1ps
`default_nettype none

`include "point_in_polygon_ray_cast_assert.svh"

module point_in_polygon_ray_cast
   import pipr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // configuration
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]        csr_index,
   input  wire logic [COORD_BITS-1:0]            csr_data,
   // vertices
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic signed [COORD_BITS-1:0]     req_vertex_x,
   input  wire logic signed [COORD_BITS-1:0]     req_vertex_y,
   input  wire logic                             req_last_vertex,
   // results
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_inside_res,
   output logic                                  rsp_too_few
);

   localparam int CW = COORD_BITS;
   localparam int DW = CW + 2;       // differences incl. ray end
   localparam int PW = 2 * DW;       // products and their differences
   localparam logic signed [DW-1:0] RAY_END = {{(DW-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

   function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
      return {{(DW-CW){v[CW-1]}}, v};
   endfunction

   function automatic orient_type orient_of(input logic signed [PW-1:0] d);
      orient_type o;
      if (d == '0)        o = ORIENT_COLL;
      else if (d[PW-1])   o = ORIENT_CCW;
      else                o = ORIENT_CW;
      return o;
   endfunction

   // side of a vertex y relative to the ray line
   function automatic orient_type side_of(input logic signed [CW-1:0] vy,
                                          input logic signed [CW-1:0] ry);
      orient_type o;
      if (vy == ry)      o = ORIENT_COLL;
      else if (vy > ry)  o = ORIENT_CCW;
      else               o = ORIENT_CW;
      return o;
   endfunction

   // ---------------- configuration ----------------
   logic signed [CW-1:0] point_x_ff, point_x_in;
   logic signed [CW-1:0] point_y_ff, point_y_in;

   assign csr_ready = 1'b1;

   always_comb begin
      point_x_in = point_x_ff;
      point_y_in = point_y_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POINT_X: point_x_in = csr_data;
            CSR_POINT_Y: point_y_in = csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- handshake control ----------------
   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s0_last_ff, s1_last_ff;
   logic s0_too_few_ff, s1_too_few_ff;
   logic req_xfer, mv0, adv1, out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign adv1      = s1_valid_ff && (!s1_last_ff || out_free);
   assign mv0       = s0_valid_ff && (!s1_valid_ff || adv1);
   assign req_stall = s0_valid_ff && s1_valid_ff && !adv1;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (req_xfer)  s0_valid_in = 1'b1;
      else if (mv0)  s0_valid_in = 1'b0;
      s1_valid_in = s1_valid_ff;
      if (mv0)       s1_valid_in = 1'b1;
      else if (adv1) s1_valid_in = 1'b0;
   end

   // ---------------- vertex tracking, input register ----------------
   logic signed [CW-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic [1:0]           count_ff, count_in;
   logic signed [CW-1:0] s0_ax_ff [2];
   logic signed [CW-1:0] s0_ay_ff [2];
   logic signed [CW-1:0] s0_bx_ff [2];
   logic signed [CW-1:0] s0_by_ff [2];
   logic                 s0_en_ff [2];

   always_comb begin
      count_in = count_ff;
      if (req_xfer) begin
         if (req_last_vertex)                        count_in = '0;
         else if (count_ff != 2'(MIN_VERTICES))      count_in = count_ff + 2'd1;
      end
   end

   // ---------------- product stage ----------------
   logic signed [DW-1:0] dx [2];
   logic signed [DW-1:0] dy [2];
   logic signed [DW-1:0] pxb [2];
   logic signed [DW-1:0] exb [2];
   logic signed [DW-1:0] pyb [2];
   logic signed [PW-1:0] m1_in [2];
   logic signed [PW-1:0] m2_in [2];
   logic signed [PW-1:0] m3_in [2];
   edge_flags_type       flags_in [2];

   logic signed [PW-1:0] s1_m1_ff [2];
   logic signed [PW-1:0] s1_m2_ff [2];
   logic signed [PW-1:0] s1_m3_ff [2];
   edge_flags_type       s1_flags_ff [2];

   // orientation of (a, b, q) is dy*(qx-bx) - dx*(qy-by); q is the point or the
   // ray end, which share y, so the dx term is common
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         dy[e]  = sx(s0_by_ff[e]) - sx(s0_ay_ff[e]);
         dx[e]  = sx(s0_bx_ff[e]) - sx(s0_ax_ff[e]);
         pxb[e] = sx(point_x_ff) - sx(s0_bx_ff[e]);
         exb[e] = RAY_END - sx(s0_bx_ff[e]);
         pyb[e] = sx(point_y_ff) - sx(s0_by_ff[e]);
         m1_in[e] = PW'(dy[e]) * PW'(pxb[e]);
         m2_in[e] = PW'(dy[e]) * PW'(exb[e]);
         m3_in[e] = PW'(dx[e]) * PW'(pyb[e]);
         flags_in[e].en  = s0_en_ff[e];
         flags_in[e].box =
            ((s0_ax_ff[e] <= point_x_ff && point_x_ff <= s0_bx_ff[e]) ||
             (s0_bx_ff[e] <= point_x_ff && point_x_ff <= s0_ax_ff[e])) &&
            ((s0_ay_ff[e] <= point_y_ff && point_y_ff <= s0_by_ff[e]) ||
             (s0_by_ff[e] <= point_y_ff && point_y_ff <= s0_ay_ff[e]));
         flags_in[e].side_diff = side_of(s0_ay_ff[e], point_y_ff) !=
                                 side_of(s0_by_ff[e], point_y_ff);
         // an end on the ray itself; the ray end lies right of every vertex
         flags_in[e].ray_touch =
            (s0_ay_ff[e] == point_y_ff && s0_ax_ff[e] >= point_x_ff) ||
            (s0_by_ff[e] == point_y_ff && s0_bx_ff[e] >= point_x_ff);
      end
   end

   // ---------------- decision stage ----------------
   logic       parity_ff, parity_in;
   logic       decided_ff, decided_in;
   logic       dval_ff, dval_in;
   logic       rsp_inside_ff, rsp_inside_in;
   logic       rsp_too_few_ff, rsp_too_few_in;
   orient_type o1 [2];
   orient_type o2 [2];
   logic       hit [2];

   always_comb begin
      for (int e = 0; e < 2; e++) begin
         o1[e]  = orient_of(s1_m1_ff[e] - s1_m3_ff[e]);
         o2[e]  = orient_of(s1_m2_ff[e] - s1_m3_ff[e]);
         hit[e] = (o1[e] != o2[e] && s1_flags_ff[e].side_diff) ||
                  (o1[e] == ORIENT_COLL && s1_flags_ff[e].box) ||
                  s1_flags_ff[e].ray_touch;
      end
   end

   always_comb begin
      parity_in      = parity_ff;
      decided_in     = decided_ff;
      dval_in        = dval_ff;
      rsp_inside_in  = rsp_inside_ff;
      rsp_too_few_in = rsp_too_few_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (adv1) begin
         // regular edge first, then the closing edge
         for (int e = 0; e < 2; e++) begin
            if (s1_flags_ff[e].en && !decided_in && hit[e]) begin
               if (o1[e] == ORIENT_COLL) begin
                  decided_in = 1'b1;
                  dval_in    = s1_flags_ff[e].box;
               end else begin
                  parity_in = !parity_in;
               end
            end
         end
         if (s1_last_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_too_few_in = s1_too_few_ff;
            rsp_inside_in  = !s1_too_few_ff && (decided_in ? dval_in : parity_in);
            parity_in      = 1'b0;
            decided_in     = 1'b0;
            dval_in        = 1'b0;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         point_x_ff   <= '0;
         point_y_ff   <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         parity_ff    <= 1'b0;
         decided_ff   <= 1'b0;
         dval_ff      <= 1'b0;
      end else begin
         point_x_ff   <= point_x_in;
         point_y_ff   <= point_y_in;
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         parity_ff    <= parity_in;
         decided_ff   <= decided_in;
         dval_ff      <= dval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         if (count_ff == 2'd0) begin
            first_x_ff <= req_vertex_x;
            first_y_ff <= req_vertex_y;
         end
         prev_x_ff     <= req_vertex_x;
         prev_y_ff     <= req_vertex_y;
         s0_ax_ff[0]   <= prev_x_ff;
         s0_ay_ff[0]   <= prev_y_ff;
         s0_bx_ff[0]   <= req_vertex_x;
         s0_by_ff[0]   <= req_vertex_y;
         s0_en_ff[0]   <= count_ff != 2'd0;
         s0_ax_ff[1]   <= req_vertex_x;
         s0_ay_ff[1]   <= req_vertex_y;
         s0_bx_ff[1]   <= first_x_ff;
         s0_by_ff[1]   <= first_y_ff;
         s0_en_ff[1]   <= req_last_vertex && count_ff >= 2'(MIN_VERTICES - 1);
         s0_last_ff    <= req_last_vertex;
         s0_too_few_ff <= count_ff < 2'(MIN_VERTICES - 1);
      end
      if (mv0) begin
         s1_m1_ff      <= m1_in;
         s1_m2_ff      <= m2_in;
         s1_m3_ff      <= m3_in;
         s1_flags_ff   <= flags_in;
         s1_last_ff    <= s0_last_ff;
         s1_too_few_ff <= s0_too_few_ff;
      end
      rsp_inside_ff  <= rsp_inside_in;
      rsp_too_few_ff <= rsp_too_few_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_too_few    = rsp_too_few_ff;

   // ---------------- assertions ----------------
   `PIPR_ASSERT_SAME(a_too_few_outside, rsp_valid_ff && rsp_too_few_ff, !rsp_inside_ff,
      "too_few result reports inside")
   `PIPR_ASSERT_NEXT(a_last_restarts, req_xfer && req_last_vertex, count_ff == 2'd0,
      "vertex count not cleared after last vertex")
   `PIPR_ASSERT_SAME(a_rsp_from_last, $rose(rsp_valid_ff), $past(adv1 && s1_last_ff),
      "result appeared without a last vertex leaving the product stage")
   `PIPR_ASSERT_SAME(a_blocked_stall,
      s0_valid_ff && s1_valid_ff && s1_last_ff && rsp_valid_ff && rsp_stall, req_stall,
      "vertex taken while the pipeline is blocked")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for point_in_polygon_ray_cast: vertices in, one verdict per polygon out.
// Depends on pipr_pkg and the RTL; the expected verdicts come from an exact integer ray-cast
// model kept here, run on every vertex transfer.
`timescale 1ns / 1ps

module testbench;
   import pipr_pkg::*;

   localparam int CW = COORD_BITS_DEFAULT;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 8'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 4;

   typedef struct {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic last;
      bit drain_first;
   } vertex_item_type;

   typedef struct {
      logic inside_val;
      logic too_few;
   } poly_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CW-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_vertex_x = '0;
   logic signed [CW-1:0] req_vertex_y = '0;
   logic req_last_vertex = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_inside_res;
   logic rsp_too_few;

   point_in_polygon_ray_cast dut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y),
      .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_inside_res(rsp_inside_res),
      .rsp_too_few(rsp_too_few)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   vertex_item_type vertex_q[$];
   poly_verdict_type verdict_q[$];

   // point registers as the block should hold them
   logic [CW-1:0] cfg_point_x = '0;
   logic [CW-1:0] cfg_point_y = '0;

   // polygon state of the model
   longint poly_first_x = 0, poly_first_y = 0, poly_prev_x = 0, poly_prev_y = 0;
   logic poly_parity = 1'b0, poly_decided = 1'b0, poly_decided_val = 1'b0;
   int poly_count = 0;

   int taken_count = 0;
   int offered_count = 0;
   int results_count = 0;
   int fail_count = 0;
   int cycle_count = 0;
   int long_hold_req = 0;
   bit offering = 0;
   bit sender_rush = 0;

   // ---------------------------------------------------------------- model

   function automatic orient_type turn_of(longint px, longint py, longint qx, longint qy,
                                          longint rx, longint ry);
      longint t;
      t = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
      if (t == 0)
         return ORIENT_COLL;
      return (t < 0) ? ORIENT_CCW : ORIENT_CW;
   endfunction

   // q inside the bounding box of p and r
   function automatic logic in_box(longint px, longint py, longint qx, longint qy,
                                   longint rx, longint ry);
      return qx <= ((px > rx) ? px : rx) && qx >= ((px < rx) ? px : rx) &&
             qy <= ((py > ry) ? py : ry) && qy >= ((py < ry) ? py : ry);
   endfunction

   function automatic void test_edge(longint ax, longint ay, longint bx, longint by);
      longint px, py, ex, ey;
      orient_type o1, o2, o3, o4;
      logic hit;
      if (poly_decided)
         return;
      px = longint'($signed(cfg_point_x));
      py = longint'($signed(cfg_point_y));
      ex = longint'(1) <<< (CW - 1);
      ey = py;
      o1 = turn_of(ax, ay, bx, by, px, py);
      o2 = turn_of(ax, ay, bx, by, ex, ey);
      o3 = turn_of(px, py, ex, ey, ax, ay);
      o4 = turn_of(px, py, ex, ey, bx, by);
      hit = (o1 != o2 && o3 != o4) ||
            (o1 == ORIENT_COLL && in_box(ax, ay, px, py, bx, by)) ||
            (o2 == ORIENT_COLL && in_box(ax, ay, ex, ey, bx, by)) ||
            (o3 == ORIENT_COLL && in_box(px, py, ax, ay, ex, ey)) ||
            (o4 == ORIENT_COLL && in_box(px, py, bx, by, ex, ey));
      if (!hit)
         return;
      // a crossed edge through the point settles the polygon
      if (turn_of(ax, ay, px, py, bx, by) == ORIENT_COLL) begin
         poly_decided = 1'b1;
         poly_decided_val = in_box(ax, ay, px, py, bx, by);
      end else begin
         poly_parity = !poly_parity;
      end
   endfunction

   function automatic void absorb_vertex(logic [CW-1:0] x_bits, logic [CW-1:0] y_bits,
                                         logic last);
      longint vx, vy;
      poly_verdict_type v;
      vx = longint'($signed(x_bits));
      vy = longint'($signed(y_bits));
      if (poly_count == 0) begin
         poly_first_x = vx;
         poly_first_y = vy;
      end else begin
         test_edge(poly_prev_x, poly_prev_y, vx, vy);
      end
      poly_prev_x = vx;
      poly_prev_y = vy;
      if (poly_count < MIN_VERTICES)
         poly_count++;
      if (!last)
         return;
      if (poly_count < MIN_VERTICES) begin
         v.inside_val = 1'b0;
         v.too_few = 1'b1;
      end else begin
         test_edge(vx, vy, poly_first_x, poly_first_y);
         v.inside_val = poly_decided ? poly_decided_val : poly_parity;
         v.too_few = 1'b0;
      end
      verdict_q = {verdict_q, v};
      poly_count = 0;
      poly_parity = 1'b0;
      poly_decided = 1'b0;
      poly_decided_val = 1'b0;
   endfunction

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      poly_verdict_type exp_v;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            absorb_vertex(req_vertex_x, req_vertex_y, req_last_vertex);
            taken_count++;
         end
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            results_count++;
            if (verdict_q.size() == 0) begin
               $display("%0t: result with no polygon pending, inside_res %0b too_few %0b",
                        $time, rsp_inside_res, rsp_too_few);
               fail_count++;
            end else begin
               exp_v = verdict_q.pop_front();
               if (rsp_inside_res !== exp_v.inside_val) begin
                  $display("%0t: inside_res mismatch, expected %0b actual %0b",
                           $time, exp_v.inside_val, rsp_inside_res);
                  fail_count++;
               end
               if (rsp_too_few !== exp_v.too_few) begin
                  $display("%0t: too_few mismatch, expected %0b actual %0b",
                           $time, exp_v.too_few, rsp_too_few);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- vertex driver

   int send_gap = 0;
   bit sender_calm = 0;

   always @(negedge clock) begin
      vertex_item_type nxt;
      // previous transfer done: draw the gap before the next vertex
      if (offering && taken_count == offered_count) begin
         offering = 0;
         send_gap = (sender_rush || sender_calm) ? 0 : $urandom_range(0, 13);
         if ($urandom_range(0, 49) == 0)
            sender_calm = !sender_calm;
      end
      if (!offering) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (vertex_q.size() != 0 &&
                      (!vertex_q[0].drain_first || verdict_q.size() == 0)) begin
            nxt = vertex_q.pop_front();
            req_vertex_x <= nxt.x;
            req_vertex_y <= nxt.y;
            req_last_vertex <= nxt.last;
            offered_count++;
            offering = 1;
         end
      end
      req_valid <= offering;
   end

   // ---------------------------------------------------------------- result receiver

   int recv_gap = 0;
   int hold_left = 0;
   int hold_seen = 0;
   int results_noted = 0;
   bit recv_calm = 0;

   always @(negedge clock) begin
      if (hold_seen != long_hold_req) begin
         hold_seen = long_hold_req;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (results_noted != results_count) begin
         results_noted = results_count;
         recv_gap = recv_calm ? 0 : $urandom_range(0, 13);
         if ($urandom_range(0, 39) == 0)
            recv_calm = !recv_calm;
      end else if (recv_gap > 0) begin
         recv_gap--;
      end
      if (hold_left > 0)
         hold_left--;
      rsp_stall <= (recv_gap > 0) || (hold_left > 0);
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic add_vertex(input int x, input int y, input int last);
      vertex_item_type item;
      item.x = CW'(x);
      item.y = CW'(y);
      item.last = (last != 0);
      item.drain_first = 0;
      vertex_q = {vertex_q, item};
   endtask

   task automatic write_point_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                                  input logic [CW-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_POINT_X)
         cfg_point_x = value;
      else if (idx == CSR_POINT_Y)
         cfg_point_y = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all vertices sent and every verdict back, plus the pipeline depth
   task automatic wait_idle();
      while (vertex_q.size() != 0 || offering || verdict_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] extreme_coord();
      case ($urandom_range(0, 4))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'h800001;
         3: return 24'hFFFFFF;
         default: return 24'h000000;
      endcase
   endfunction

   function automatic logic [CW-1:0] coord_near(logic [CW-1:0] center);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 35)
         return CW'(center + $urandom_range(0, 12) - 6);
      if (sel < 50)
         return center;
      if (sel < 80)
         return CW'($urandom);
      if (sel < 90)
         return extreme_coord();
      return CW'(center + $urandom_range(0, 65535) - 32768);
   endfunction

   function automatic logic [CW-1:0] pick_point();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 15)
         return extreme_coord();
      if (sel < 35)
         return CW'($urandom_range(0, 32) - 16);
      return CW'($urandom);
   endfunction

   // shape 0: ring around the point, 1: scatter near the point, 2: noise
   task automatic push_polygon(input int count, input int shape, input bit drain_first);
      vertex_item_type item;
      logic [CW-1:0] dx, dy;
      int quad, scale;
      scale = $urandom_range(0, CW - 2);
      for (int i = 0; i < count; i++) begin
         case (shape)
            0: begin
               quad = (i * 4) / count;
               dx = CW'($urandom_range(0, 1 << scale));
               dy = CW'($urandom_range(0, 1 << scale));
               item.x = (quad == 0 || quad == 3) ? cfg_point_x + dx : cfg_point_x - dx;
               item.y = (quad < 2) ? cfg_point_y + dy : cfg_point_y - dy;
            end
            1: begin
               item.x = coord_near(cfg_point_x);
               item.y = coord_near(cfg_point_y);
            end
            default: begin
               item.x = CW'($urandom);
               item.y = CW'($urandom);
            end
         endcase
         item.last = (i == count - 1);
         item.drain_first = drain_first && (i == 0);
         vertex_q = {vertex_q, item};
      end
   endtask

   function automatic int pick_count();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 85)
         return $urandom_range(3, 8);
      if (sel < 93)
         return $urandom_range(1, 2);
      return $urandom_range(9, 20);
   endfunction

   initial begin
      int pushed, drain_at, count;
      bit drained;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed: point at the origin
      add_vertex(5, 5, 1);                 // single vertex
      add_vertex(-3, 0, 0);                // two vertices
      add_vertex(3, 0, 1);
      add_vertex(-10, -10, 0);             // plain enclosing triangle
      add_vertex(10, -10, 0);
      add_vertex(0, 10, 1);
      add_vertex(-5, 0, 0);                // point on a horizontal edge along the ray
      add_vertex(5, 0, 0);
      add_vertex(0, 5, 1);
      add_vertex(24'h800000, 24'h800000, 0);
      add_vertex(24'h7FFFFF, 24'h800000, 0);
      add_vertex(0, 24'h7FFFFF, 1);
      add_vertex(0, 0, 0);                 // point equals a vertex
      add_vertex(10, 10, 0);
      add_vertex(10, -10, 1);
      add_vertex(-10, -10, 0);             // vertex lying on the ray
      add_vertex(10, 0, 0);
      add_vertex(-10, 10, 1);
      add_vertex(-20, -20, 0);             // polygon split by register writes
      add_vertex(20, -20, 0);
      wait_idle();
      write_point_reg(CSR_POINT_X, 24'h7FFFFF);
      write_point_reg(CSR_POINT_Y, 24'h800000);
      write_point_reg(CSR_UNMAPPED, 24'h123456);
      add_vertex(20, 20, 0);
      add_vertex(-20, 20, 1);
      add_vertex(24'h800000, 24'h800000, 0);
      add_vertex(24'h7FFFFF, 24'h7FFFFF, 0);
      add_vertex(24'h7FFFFF, 24'h800000, 1);

      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         write_point_reg(CSR_POINT_X, pick_point());
         if (phase % 3 != 2)
            write_point_reg(CSR_POINT_Y, pick_point());
         if (phase == 4) begin
            // receiver holds off while vertices keep coming back to back
            sender_rush = 1;
            long_hold_req++;
            for (int k = 0; k < 70; k++)
               push_polygon(3, $urandom_range(0, 2), 0);
            while (vertex_q.size() != 0)
               @(posedge clock);
            sender_rush = 0;
         end else begin
            pushed = 0;
            drained = 0;
            drain_at = $urandom_range(10, 130);
            while (pushed < 150) begin
               count = pick_count();
               push_polygon(count, $urandom_range(0, 99) < 55 ? 0 :
                            ($urandom_range(0, 1) ? 1 : 2),
                            !drained && pushed >= drain_at);
               if (pushed >= drain_at)
                  drained = 1;
               pushed += count;
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pipr_pkg.sv
hw/rtl/point_in_polygon_ray_cast.sv
tb/sv/testbench.sv
